### sv/sdaf_pkg.sv
// Shared types and constants for the snapshot dedup admission filter.
`default_nettype none

package sdaf_pkg;

   localparam int DEFAULT_WINDOW_DEPTH = 64;
   localparam int DEFAULT_INDEX_BITS   = 48;

   localparam int FIELD_W = 48;
   localparam int EXT_W   = 64;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUTOFF_ENABLE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUTOFF_INDEX  = 1'd1;

   typedef enum logic [1:0] {
      VERDICT_ACCEPTED  = 2'd0,
      VERDICT_MISSING   = 2'd1,
      VERDICT_STALE     = 2'd2,
      VERDICT_DUPLICATE = 2'd3
   } verdict_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } win_cmd_type;

endpackage

`default_nettype wire

### sv/sdaf_window.sv
// Ring window store of admitted indices with fill count and write slot.
`default_nettype none

module sdaf_window #(
   parameter int WINDOW_DEPTH = sdaf_pkg::DEFAULT_WINDOW_DEPTH,
   parameter int INDEX_BITS   = sdaf_pkg::DEFAULT_INDEX_BITS,
   localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
   localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sdaf_pkg::win_cmd_type cmd,
   input  wire logic [ADDR_W-1:0]     rd_addr,
   input  wire logic [INDEX_BITS-1:0] wr_data,
   output logic [INDEX_BITS-1:0]      rd_data,
   output logic [CNT_W-1:0]           fill
);

   logic [INDEX_BITS-1:0] mem [WINDOW_DEPTH];
   logic [INDEX_BITS-1:0] rd_data_ff;
   logic [ADDR_W-1:0]     slot_ff, slot_in;
   logic [CNT_W-1:0]      fill_ff, fill_in;

   always_comb begin
      slot_in = slot_ff;
      fill_in = fill_ff;
      if (cmd.wr_en) begin
         if (slot_ff == ADDR_W'(WINDOW_DEPTH - 1)) begin
            slot_in = '0;
         end else begin
            slot_in = slot_ff + ADDR_W'(1);
         end
         if (fill_ff != CNT_W'(WINDOW_DEPTH)) begin
            fill_in = fill_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         fill_ff <= '0;
      end else begin
         slot_ff <= slot_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[slot_ff] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign fill    = fill_ff;

endmodule

`default_nettype wire

### sv/snapshot_dedup_admission_filter.sv
// Top level of the snapshot dedup admission filter: sequencer, cutoff registers and verdicts.
//
// An item is taken when start is high and busy is low; its verdict appears on rsp_verdict
// with rsp_valid high for exactly one cycle, and the receiver cannot stall it. A missing or
// stale verdict, or an accepted one when the window is empty, is decided in the check state
// and registered as the verdict. Otherwise the window is scanned one entry per cycle through
// its single read port and one shared equality comparator: the check state reads the first
// entry, and each scan step compares the entry read and reads the entry after it. Up to the
// current fill, at most WINDOW_DEPTH, entries are compared for an accepted item. Busy falls in
// the cycle the verdict is shown, so a new item may start in that cycle. The window needs no
// clearing pass after reset.
`default_nettype none

module snapshot_dedup_admission_filter #(
   parameter int WINDOW_DEPTH = sdaf_pkg::DEFAULT_WINDOW_DEPTH,
   parameter int INDEX_BITS   = sdaf_pkg::DEFAULT_INDEX_BITS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [sdaf_pkg::FIELD_W-1:0]     req_submit_index,
   output logic                                  rsp_valid,
   output logic [1:0]                            rsp_verdict,
   input  wire logic                             csr_write_enable,
   input  wire logic [sdaf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [sdaf_pkg::FIELD_W-1:0]     csr_write_data
);

   localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN
   } state_type;

   state_type                     state_ff, state_in;
   logic [INDEX_BITS-1:0]         key_ff, key_in;
   logic [ADDR_W-1:0]             ptr_ff, ptr_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   sdaf_pkg::verdict_type         verdict_ff, verdict_in;

   logic                          cutoff_enable_ff;
   logic [sdaf_pkg::FIELD_W-1:0]  cutoff_index_ff;

   logic [sdaf_pkg::EXT_W-1:0]    req_ext, cut_ext;
   logic [INDEX_BITS-1:0]         cut_key;
   sdaf_pkg::win_cmd_type         win_cmd;
   logic [ADDR_W-1:0]             rd_addr;
   logic [INDEX_BITS-1:0]         rd_data;
   logic [CNT_W-1:0]              fill;
   logic                          scan_last;

   assign req_ext   = sdaf_pkg::EXT_W'(req_submit_index);
   assign cut_ext   = sdaf_pkg::EXT_W'(cutoff_index_ff);
   assign cut_key   = cut_ext[INDEX_BITS-1:0];
   assign scan_last = (CNT_W'(ptr_ff) + CNT_W'(1)) == fill;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_enable_ff <= 1'b0;
         cutoff_index_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            sdaf_pkg::CSR_CUTOFF_ENABLE: cutoff_enable_ff <= csr_write_data[0];
            sdaf_pkg::CSR_CUTOFF_INDEX:  cutoff_index_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      ptr_in       = ptr_ff;
      rsp_valid_in = 1'b0;
      verdict_in   = verdict_ff;
      win_cmd      = '0;
      rd_addr      = ptr_ff + ADDR_W'(1);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in   = req_ext[INDEX_BITS-1:0];
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            rd_addr = '0;
            ptr_in  = '0;
            if (key_ff == '0) begin
               verdict_in   = sdaf_pkg::VERDICT_MISSING;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (cutoff_enable_ff && (key_ff <= cut_key)) begin
               verdict_in   = sdaf_pkg::VERDICT_STALE;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (fill == '0) begin
               win_cmd.wr_en = 1'b1;
               verdict_in    = sdaf_pkg::VERDICT_ACCEPTED;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               win_cmd.rd_en = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_data == key_ff) begin
               verdict_in   = sdaf_pkg::VERDICT_DUPLICATE;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (scan_last) begin
               win_cmd.wr_en = 1'b1;
               verdict_in    = sdaf_pkg::VERDICT_ACCEPTED;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               win_cmd.rd_en = 1'b1;
               ptr_in        = ptr_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         verdict_ff   <= sdaf_pkg::VERDICT_ACCEPTED;
         ptr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         verdict_ff   <= verdict_in;
         ptr_ff       <= ptr_in;
      end
      key_ff <= key_in;
   end

   sdaf_window #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .INDEX_BITS   (INDEX_BITS)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .cmd     (win_cmd),
      .rd_addr (rd_addr),
      .wr_data (key_ff),
      .rd_data (rd_data),
      .fill    (fill)
   );

   assign busy        = state_ff != ST_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = verdict_ff;

endmodule

`default_nettype wire

### sv/sdaf_checker.sv
// Port-level checker for the snapshot dedup admission filter and its bind.
`default_nettype none

module sdaf_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         start,
   input wire logic                         busy,
   input wire logic [sdaf_pkg::FIELD_W-1:0] req_submit_index,
   input wire logic                         rsp_valid,
   input wire logic [1:0]                   rsp_verdict
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an item was taken");

   a_idle_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in adjacent cycles");

   a_missing_verdict: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_submit_index == '0)) |=> ##1
         (rsp_valid && (rsp_verdict == sdaf_pkg::VERDICT_MISSING)))
      else $error("zero index did not give a missing verdict in time");

   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("block not idle after reset");

endmodule

bind snapshot_dedup_admission_filter sdaf_checker u_sdaf_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_submit_index (req_submit_index),
   .rsp_valid        (rsp_valid),
   .rsp_verdict      (rsp_verdict)
);

`default_nettype wire
